// ----- rtl/mudcc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mudcc_pkg
// Codes and signatures shared by the user-data caption and AFD parser.
// ----------------------------------------------------------------------------
package mudcc_pkg;

  // Block signatures, first byte in the low lane.
  localparam logic [31:0] SIG_DVD  = 32'hf801_4343;
  localparam logic [31:0] SIG_AFD  = 32'h3147_5444;
  localparam logic [31:0] SIG_ATSC = 32'h3439_4147;

  localparam logic [7:0] AFD_ID      = 8'd65;
  localparam logic [7:0] ATSC_TYPE   = 8'h03;
  localparam logic [7:0] CC_TRIPLET  = 8'hFC;
  localparam logic [7:0] START_CODE  = 8'hB2;

  typedef logic [1:0] blk_kind_t;
  localparam blk_kind_t BK_NONE = 2'd0;
  localparam blk_kind_t BK_DVD  = 2'd1;
  localparam blk_kind_t BK_AFD  = 2'd2;
  localparam blk_kind_t BK_ATSC = 2'd3;

  typedef logic [2:0] res_kind_t;
  localparam res_kind_t RK_MARK = 3'd0;
  localparam res_kind_t RK_PASS = 3'd1;
  localparam res_kind_t RK_HDR  = 3'd2;
  localparam res_kind_t RK_PAIR = 3'd3;
  localparam res_kind_t RK_AFD  = 3'd4;

  localparam int PAIR_DEPTH = 31;
  localparam logic [6:0] POS_MAX = 7'd127;

endpackage

// ----- rtl/mpeg_user_data_cc_afd_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpeg_user_data_cc_afd_parser
// Byte-serial parser for MPEG-2 user-data blocks: DVD caption passthrough,
// AFD change reports and ATSC caption pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Bytes of a user-data block enter on the in_ channel, one item per byte,
//   with first/last flags and the GOP and key-frame qualifiers. Results leave
//   on the out_ channel through an output register; run_last marks the last
//   result caused by one input byte.
//   A byte that causes no result or a single result leaves the parser idle,
//   so ordinary block bytes stream at one per cycle while the output does
//   not stall. Byte 4 of a DVD caption block causes six results, emitted one
//   per cycle while the output does not stall. The last byte of an ATSC
//   caption block causes a count header and then up to 31 pairs, each read
//   from the pair memory (ST_RD) before it is emitted (ST_PAIR). in_stall
//   is high during these runs.
//   A stalled output holds its result and, through in_stall, the input.
//   Reset (rst_n low at a clock edge) clears the parse state, the AFD code
//   and the enable register; the pair memory is not cleared, since only
//   pairs written in the current block are ever read.
//   cc_out_enabled lies at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module mpeg_user_data_cc_afd_parser (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_data_byte,
  input  logic                   in_first_byte,
  input  logic                   in_last_byte,
  input  logic                   in_gop_header,
  input  logic                   in_wait_key_frame,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output mudcc_pkg::res_kind_t   out_kind,
  output logic [7:0]             out_out_byte,
  output logic [7:0]             out_cc_first,
  output logic [7:0]             out_cc_second,
  output logic                   out_run_last,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import mudcc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DVD  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_PAIR = 2'd3;

  // Pair memory: one byte pair per kept triplet.
  logic [15:0] pair_mem [PAIR_DEPTH];
  logic [15:0] rd_data_r;

  logic        cfg_en_r;
  logic [1:0]  st_r, st_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [31:0] sig_r, sig_nxt;
  blk_kind_t   kind_r, kind_nxt;
  logic [4:0]  left_r, left_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        kept_r, kept_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [3:0]  afd_r, afd_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  dvd_byte_r;
  logic [4:0]  idx_r, idx_nxt;
  logic [4:0]  flush_n_r;

  logic        out_valid_r;
  res_kind_t   out_kind_r;
  logic [7:0]  out_byte_r, out_c1_r, out_c2_r;
  logic        out_last_r;

  logic        in_acc, out_load;
  logic        wr_en;
  logic [4:0]  wr_addr;

  // per-byte step
  logic [6:0]  pos_e;
  blk_kind_t   kind_e;
  logic        s_emit, s_last, s_go_dvd, s_go_flush;
  res_kind_t   s_kind;
  logic [7:0]  s_byte;

  // emission toward the output register
  logic        e_valid, e_last;
  res_kind_t   e_kind;
  logic [7:0]  e_byte, e_c1, e_c2;

  assign pready   = 1'b1;
  assign prdata   = {31'd0, cfg_en_r};
  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = (st_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_en_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      cfg_en_r <= pwdata[0];
    end
  end

  always_comb begin
    pos_e     = in_first_byte ? 7'd0 : pos_r;
    kind_e    = in_first_byte ? BK_NONE : kind_r;
    left_nxt  = in_first_byte ? 5'd0 : left_r;
    phase_nxt = in_first_byte ? 2'd0 : phase_r;
    kept_nxt  = in_first_byte ? 1'b0 : kept_r;
    cnt_nxt   = in_first_byte ? 5'd0 : cnt_r;
    kind_nxt  = kind_e;
    sig_nxt   = sig_r;
    afd_nxt   = afd_r;
    lo_nxt    = lo_r;
    wr_en     = 1'b0;
    wr_addr   = cnt_nxt;
    s_emit    = 1'b0;
    s_kind    = RK_PASS;
    s_byte    = in_data_byte;
    s_last    = 1'b1;
    s_go_dvd  = 1'b0;
    s_go_flush = 1'b0;

    if (pos_e < 7'd4) begin
      // All four lanes are rewritten before the signature is compared, so no clear is needed.
      sig_nxt[8*pos_e[1:0] +: 8] = in_data_byte;
    end else if (pos_e == 7'd4) begin
      if (in_gop_header && cfg_en_r && sig_r == SIG_DVD) begin
        kind_nxt = BK_DVD;
        s_emit   = 1'b1;
        s_kind   = RK_MARK;
        s_byte   = START_CODE;
        s_last   = 1'b0;
        s_go_dvd = 1'b1;
      end else if (sig_r == SIG_AFD && in_data_byte == AFD_ID) begin
        kind_nxt = BK_AFD;
      end else if (sig_r == SIG_ATSC && in_data_byte == ATSC_TYPE && cfg_en_r) begin
        kind_nxt = BK_ATSC;
      end
    end else if (kind_e == BK_DVD) begin
      s_emit = 1'b1;
    end else if (pos_e == 7'd5) begin
      if (kind_e == BK_AFD) begin
        if (!in_wait_key_frame && in_data_byte[3:0] != afd_r) begin
          afd_nxt = in_data_byte[3:0];
          s_emit  = 1'b1;
          s_kind  = RK_AFD;
          s_byte  = {4'd0, in_data_byte[3:0]};
        end
        kind_nxt = BK_NONE;
      end else if (kind_e == BK_ATSC) begin
        if (in_data_byte[6]) begin
          left_nxt = in_data_byte[4:0];
        end else begin
          kind_nxt = BK_NONE;
        end
      end
    end else if (pos_e >= 7'd7 && kind_e == BK_ATSC && left_nxt != 5'd0) begin
      case (phase_nxt)
        2'd0: begin
          kept_nxt  = (in_data_byte == CC_TRIPLET);
          phase_nxt = 2'd1;
        end
        2'd1: begin
          if (kept_nxt) begin
            lo_nxt = in_data_byte;
          end
          phase_nxt = 2'd2;
        end
        default: begin
          if (kept_nxt && cnt_nxt != 5'(PAIR_DEPTH)) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_nxt + 5'd1;
          end
          kept_nxt  = 1'b0;
          phase_nxt = 2'd0;
          left_nxt  = left_nxt - 5'd1;
        end
      endcase
    end

    pos_nxt = (pos_e != POS_MAX) ? pos_e + 7'd1 : pos_e;

    if (in_last_byte) begin
      if (kind_nxt == BK_ATSC && cnt_nxt != 5'd0) begin
        s_emit     = 1'b1;
        s_kind     = RK_HDR;
        s_byte     = {2'b10, cnt_nxt, 1'b0};
        s_last     = 1'b0;
        s_go_flush = 1'b1;
      end
      pos_nxt   = 7'd0;
      kind_nxt  = BK_NONE;
      left_nxt  = 5'd0;
      phase_nxt = 2'd0;
      kept_nxt  = 1'b0;
      cnt_nxt   = 5'd0;
    end
  end

  // Result sequencer.
  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    e_valid = 1'b0;
    e_kind  = RK_PASS;
    e_byte  = 8'd0;
    e_c1    = 8'd0;
    e_c2    = 8'd0;
    e_last  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          e_valid = s_emit;
          e_kind  = s_kind;
          e_byte  = s_byte;
          e_last  = s_last;
          idx_nxt = s_go_dvd ? 5'd1 : 5'd0;
          if (s_go_dvd) begin
            st_nxt = ST_DVD;
          end else if (s_go_flush) begin
            st_nxt = ST_RD;
          end
        end
      end
      ST_DVD: begin
        if (out_load) begin
          e_valid = 1'b1;
          case (idx_r)
            5'd1:    e_byte = sig_r[7:0];
            5'd2:    e_byte = sig_r[15:8];
            5'd3:    e_byte = sig_r[23:16];
            5'd4:    e_byte = sig_r[31:24];
            default: e_byte = dvd_byte_r;
          endcase
          if (idx_r == 5'd5) begin
            e_last = 1'b1;
            st_nxt = ST_IDLE;
          end
          idx_nxt = idx_r + 5'd1;
        end
      end
      ST_RD: begin
        // rd_data_r picks up the entry at idx_r during this cycle.
        st_nxt = ST_PAIR;
      end
      ST_PAIR: begin
        if (out_load) begin
          e_valid = 1'b1;
          e_kind  = RK_PAIR;
          e_c1    = rd_data_r[7:0];
          e_c2    = rd_data_r[15:8];
          if (idx_r == flush_n_r - 5'd1) begin
            e_last = 1'b1;
            st_nxt = ST_IDLE;
          end else begin
            st_nxt = ST_RD;
          end
          idx_nxt = idx_r + 5'd1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      pos_r       <= 7'd0;
      sig_r       <= 32'd0;
      kind_r      <= BK_NONE;
      left_r      <= 5'd0;
      phase_r     <= 2'd0;
      kept_r      <= 1'b0;
      cnt_r       <= 5'd0;
      afd_r       <= 4'd0;
      idx_r       <= 5'd0;
      flush_n_r   <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      if (in_acc) begin
        pos_r   <= pos_nxt;
        sig_r   <= sig_nxt;
        kind_r  <= kind_nxt;
        left_r  <= left_nxt;
        phase_r <= phase_nxt;
        kept_r  <= kept_nxt;
        cnt_r   <= cnt_nxt;
        afd_r   <= afd_nxt;
        if (s_go_flush) begin
          flush_n_r <= s_byte[5:1];
        end
      end
      if (out_load) begin
        out_valid_r <= e_valid;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      lo_r <= lo_nxt;
      if (s_go_dvd) begin
        dvd_byte_r <= in_data_byte;
      end
    end
    if (out_load) begin
      out_kind_r <= e_kind;
      out_byte_r <= e_byte;
      out_c1_r   <= e_c1;
      out_c2_r   <= e_c2;
      out_last_r <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && wr_en) begin
      pair_mem[wr_addr] <= {in_data_byte, lo_r};
    end
    rd_data_r <= pair_mem[idx_r];
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_out_byte  = out_byte_r;
  assign out_cc_first  = out_c1_r;
  assign out_cc_second = out_c2_r;
  assign out_run_last  = out_last_r;

  // A memory read state is always followed by the pair emission state.
  a_rd_then_pair: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RD |=> st_r == ST_PAIR)
    else $error("pair read not followed by pair emission");

  a_pair_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_PAIR |-> idx_r < flush_n_r)
    else $error("pair index beyond flush count");

  a_triplets_atsc: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r != 5'd0 || phase_r != 2'd0) |-> kind_r == BK_ATSC)
    else $error("triplet state outside an ATSC block");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the user-data caption and AFD parser. Block bytes
// are fed one item at a time. A predictor written here computes the results
// that each accepted byte should cause, and every result leaving the block is
// compared field by field against the oldest prediction. A short directed
// table comes first, then random blocks under three idle and stall patterns.
// The caption enable is written anew before each phase.
// ----------------------------------------------------------------------------
module testbench;
  import mudcc_pkg::*;

  localparam logic [2:0] CC_OUT_ENABLED_ADDR = 3'd0;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS = 40_000_000;
  localparam int PHASE_ITEMS = 40;
  localparam logic [5:0] CC_PLAN = 6'b110101;

  typedef struct packed {
    logic [7:0] data;
    logic       blk_first;
    logic       blk_last;
    logic       gop;
    logic       wait_kf;
  } cc_item_t;

  typedef struct packed {
    res_kind_t  kind;
    logic [7:0] byte_val;
    logic [7:0] cc1;
    logic [7:0] cc2;
    logic       run_last;
  } cc_result_t;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_SINGLE, ROW_SET_CC} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic [7:0] data;
    logic       blk_first;
    logic       blk_last;
    logic       gop;
    logic       wait_kf;
    res_kind_t  want_kind;
    logic [7:0] want_byte;
  } dir_row_t;

  localparam int N_DIRECTED = 27;
  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{ROW_SET_CC,  8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    // AFD block right after reset: the code moves from 0 to 15.
    '{ROW_PREDICT, 8'h44, 1'b1, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h54, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h47, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h31, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_SINGLE,  8'hFF, 1'b0, 1'b1, 1'b1, 1'b0, RK_AFD,  8'h0F},
    // A block that ends inside its signature causes nothing.
    '{ROW_QUIET,   8'h44, 1'b1, 1'b0, 1'b0, 1'b1, RK_MARK, 8'h00},
    '{ROW_QUIET,   8'h54, 1'b0, 1'b0, 1'b1, 1'b1, RK_MARK, 8'h00},
    '{ROW_QUIET,   8'h47, 1'b0, 1'b1, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_SET_CC,  8'h01, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    // DVD caption block in a GOP header.
    '{ROW_PREDICT, 8'h43, 1'b1, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h43, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'hF8, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, RK_MARK, 8'h00},
    // ATSC caption block with a single kept triplet.
    '{ROW_PREDICT, 8'h47, 1'b1, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h39, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h34, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h03, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'hFC, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, RK_MARK, 8'h00},
    '{ROW_PREDICT, 8'hFF, 1'b0, 1'b1, 1'b0, 1'b0, RK_MARK, 8'h00}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic        in_gop_header = 1'b0;
  logic        in_wait_key_frame = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  res_kind_t   out_kind;
  logic [7:0]  out_out_byte;
  logic [7:0]  out_cc_first;
  logic [7:0]  out_cc_second;
  logic        out_run_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state.
  logic        cc_enable = 1'b0;
  logic [6:0]  parse_pos = 7'd0;
  logic [31:0] sig_word = 32'd0;
  blk_kind_t   cur_block = BK_NONE;
  logic [4:0]  trip_count = 5'd0;
  logic [1:0]  trip_step = 2'd0;
  logic        trip_keep = 1'b0;
  logic [15:0] pair_mem [0:PAIR_DEPTH-1];
  logic [4:0]  pair_total = 5'd0;
  logic [3:0]  afd_code = 4'h0;

  cc_result_t  expected_q [$];
  cc_item_t    block_q [$];
  bit          block_open = 1'b0;
  int          mismatches = 0;
  int          send_idle_pct = 10;
  int          stall_pct = 67;

  mpeg_user_data_cc_afd_parser dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task flag_mismatch(input string msg);
    if (mismatches < 100) $display("ERROR: %s", msg);
    mismatches++;
  endtask

  task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %02h want %02h", name, got, want));
  endtask

  // Results are taken at the coming edge; outputs and stall are stable here.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d byte %02h", out_kind, out_out_byte));
      end else begin
        check_field("kind", {5'd0, out_kind}, {5'd0, expected_q[0].kind});
        check_field("out_byte", out_out_byte, expected_q[0].byte_val);
        check_field("cc_first", out_cc_first, expected_q[0].cc1);
        check_field("cc_second", out_cc_second, expected_q[0].cc2);
        check_field("run_last", {7'd0, out_run_last}, {7'd0, expected_q[0].run_last});
        void'(expected_q.pop_front());
      end
    end
  end

  function automatic cc_result_t mk_result(res_kind_t k, logic [7:0] b, logic [7:0] c1,
                                           logic [7:0] c2);
    cc_result_t r;
    r.kind = k;
    r.byte_val = b;
    r.cc1 = c1;
    r.cc2 = c2;
    r.run_last = 1'b0;
    return r;
  endfunction

  function void clear_block();
    parse_pos = 7'd0;
    sig_word = 32'd0;
    cur_block = BK_NONE;
    trip_count = 5'd0;
    trip_step = 2'd0;
    trip_keep = 1'b0;
    pair_total = 5'd0;
  endfunction

  // Works out the results of one byte and, when asked, queues them.
  task automatic predict_byte(input cc_item_t it, input bit publish);
    cc_result_t run_q [$];
    logic [6:0] pos;
    logic [4:0] slot;
    if (it.blk_first) clear_block();
    pos = parse_pos;
    if (pos < 7'd4) begin
      sig_word[8*int'(pos) +: 8] = it.data;
    end else if (pos == 7'd4) begin
      if (it.gop && cc_enable && sig_word == SIG_DVD) begin
        cur_block = BK_DVD;
        run_q.push_back(mk_result(RK_MARK, START_CODE, 8'h00, 8'h00));
        for (int i = 0; i < 4; i++)
          run_q.push_back(mk_result(RK_PASS, sig_word[8*i +: 8], 8'h00, 8'h00));
        run_q.push_back(mk_result(RK_PASS, it.data, 8'h00, 8'h00));
      end else if (sig_word == SIG_AFD && it.data == AFD_ID) begin
        cur_block = BK_AFD;
      end else if (sig_word == SIG_ATSC && it.data == ATSC_TYPE && cc_enable) begin
        cur_block = BK_ATSC;
      end
    end else if (cur_block == BK_DVD) begin
      run_q.push_back(mk_result(RK_PASS, it.data, 8'h00, 8'h00));
    end else if (pos == 7'd5) begin
      if (cur_block == BK_AFD) begin
        if (!it.wait_kf && it.data[3:0] != afd_code) begin
          afd_code = it.data[3:0];
          run_q.push_back(mk_result(RK_AFD, {4'h0, afd_code}, 8'h00, 8'h00));
        end
        cur_block = BK_NONE;
      end else if (cur_block == BK_ATSC) begin
        if (it.data[6]) trip_count = it.data[4:0];
        else cur_block = BK_NONE;
      end
    end else if (pos >= 7'd7 && cur_block == BK_ATSC && trip_count != 5'd0) begin
      // Once the store is full, further kept pairs overwrite the last slot, high byte zeroed.
      slot = (pair_total < PAIR_DEPTH) ? pair_total : 5'(PAIR_DEPTH - 1);
      case (trip_step)
        2'd0: begin
          trip_keep = (it.data == CC_TRIPLET);
          trip_step = 2'd1;
        end
        2'd1: begin
          if (trip_keep) pair_mem[slot] = {8'h00, it.data};
          trip_step = 2'd2;
        end
        default: begin
          if (trip_keep && pair_total < PAIR_DEPTH) begin
            pair_mem[slot][15:8] = it.data;
            pair_total++;
          end
          trip_keep = 1'b0;
          trip_step = 2'd0;
          trip_count--;
        end
      endcase
    end
    if (parse_pos != POS_MAX) parse_pos++;
    if (it.blk_last) begin
      if (cur_block == BK_ATSC && pair_total != 5'd0) begin
        run_q.push_back(mk_result(RK_HDR, 8'h80 | {2'b00, pair_total, 1'b0}, 8'h00, 8'h00));
        for (int i = 0; i < int'(pair_total); i++)
          run_q.push_back(mk_result(RK_PAIR, 8'h00, pair_mem[i][7:0], pair_mem[i][15:8]));
      end
      clear_block();
    end
    if (run_q.size() != 0) run_q[run_q.size()-1].run_last = 1'b1;
    if (publish) begin
      foreach (run_q[i]) expected_q.push_back(run_q[i]);
    end
  endtask

  task send_byte(input cc_item_t it);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= it.data;
    in_first_byte <= it.blk_first;
    in_last_byte <= it.blk_last;
    in_gop_header <= it.gop;
    in_wait_key_frame <= it.wait_kf;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Holds the input back until every result is out and the block has gone quiet.
  task settle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_cc_enable(input logic value);
    logic rdy;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CC_OUT_ENABLED_ADDR;
    pwdata <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cc_enable = value;
  endtask

  // Builds one block of bytes in block_q. Most blocks carry a valid signature
  // and plausible content; some are cut short, left open or pure noise.
  task automatic make_block(input bit long_dvd);
    logic [7:0]  raw_q [$];
    logic [31:0] sig;
    int          pick;
    int          cnt;
    int          cut;
    bit          dvd_gop;
    bit          afd_wait;
    bit          open_end;
    cc_item_t    it;
    pick = long_dvd ? 0 : $urandom_range(99);
    dvd_gop = ($urandom_range(9) != 0);
    afd_wait = ($urandom_range(3) == 0);
    if (pick < 30) sig = SIG_DVD;
    else if (pick < 50) sig = SIG_AFD;
    else if (pick < 85) sig = SIG_ATSC;
    else begin
      sig = $urandom();
      if ($urandom_range(1) == 1) begin
        case ($urandom_range(2))
          0: sig = SIG_DVD;
          1: sig = SIG_AFD;
          default: sig = SIG_ATSC;
        endcase
        cut = $urandom_range(3);
        sig[8*cut +: 8] = sig[8*cut +: 8] ^ 8'(1 + $urandom_range(254));
      end
    end
    for (int i = 0; i < 4; i++) raw_q.push_back(sig[8*i +: 8]);
    if (pick < 30) begin
      repeat (long_dvd ? 131 : 1 + $urandom_range(12)) raw_q.push_back(8'($urandom_range(255)));
    end else if (pick < 50) begin
      raw_q.push_back(($urandom_range(7) != 0) ? AFD_ID : 8'($urandom_range(255)));
      raw_q.push_back(8'($urandom_range(255)));
      repeat ($urandom_range(2)) raw_q.push_back(8'($urandom_range(255)));
    end else if (pick < 85) begin
      raw_q.push_back(($urandom_range(9) != 0) ? ATSC_TYPE : 8'($urandom_range(255)));
      cnt = ($urandom_range(15) == 0) ? 31 : $urandom_range(6);
      if ($urandom_range(9) != 0)
        raw_q.push_back({1'($urandom_range(1)), 1'b1, 1'($urandom_range(1)), 5'(cnt)});
      else
        raw_q.push_back(8'($urandom_range(255)) & 8'hBF);
      raw_q.push_back(8'($urandom_range(255)));
      repeat (cnt) begin
        raw_q.push_back(($urandom_range(3) != 0) ? CC_TRIPLET : 8'($urandom_range(255)));
        raw_q.push_back(8'($urandom_range(255)));
        raw_q.push_back(8'($urandom_range(255)));
      end
      repeat ($urandom_range(2)) raw_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(4)) raw_q.push_back(8'($urandom_range(255)));
    end
    if (!long_dvd && $urandom_range(7) == 0) begin
      cut = 1 + $urandom_range(raw_q.size() - 1);
      while (raw_q.size() > cut) void'(raw_q.pop_back());
    end
    open_end = ($urandom_range(9) == 0);
    block_q.delete();
    foreach (raw_q[i]) begin
      it.data = raw_q[i];
      // A block left open before must be restarted explicitly.
      it.blk_first = (i == 0) ? (block_open ? 1'b1 : 1'($urandom_range(1))) : 1'b0;
      it.blk_last = (i == raw_q.size() - 1) && !open_end;
      it.gop = (i == 4 && pick < 30) ? dvd_gop : 1'($urandom_range(1));
      it.wait_kf = (i == 5 && pick >= 30 && pick < 50) ? afd_wait : 1'($urandom_range(1));
      block_q.push_back(it);
    end
    block_open = open_end;
  endtask

  initial begin : stimulus
    cc_item_t   it;
    cc_result_t single;
    int         counted;
    clear_block();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].op == ROW_SET_CC) begin
        settle();
        write_cc_enable(DIRECTED[i].data[0]);
      end else begin
        it.data = DIRECTED[i].data;
        it.blk_first = DIRECTED[i].blk_first;
        it.blk_last = DIRECTED[i].blk_last;
        it.gop = DIRECTED[i].gop;
        it.wait_kf = DIRECTED[i].wait_kf;
        send_byte(it);
        predict_byte(it, DIRECTED[i].op == ROW_PREDICT);
        if (DIRECTED[i].op == ROW_SINGLE) begin
          single = mk_result(DIRECTED[i].want_kind, DIRECTED[i].want_byte, 8'h00, 8'h00);
          single.run_last = 1'b1;
          expected_q.push_back(single);
        end
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 10 : (ph < 4) ? 67 : 0;
      stall_pct = (ph < 2) ? 67 : (ph < 4) ? 10 : 0;
      settle();
      write_cc_enable(CC_PLAN[ph]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        // The last phase opens with one block long enough to saturate the position.
        make_block(ph == 5 && counted == 0);
        foreach (block_q[j]) begin
          send_byte(block_q[j]);
          predict_byte(block_q[j], 1'b1);
        end
        counted += block_q.size();
      end
    end

    in_valid <= 1'b0;
    for (int k = 0; k < 20000 && expected_q.size() != 0; k++) @(posedge clk);
    if (expected_q.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", expected_q.size()));
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("simulation failed");
    $finish;
  end

endmodule
